>>> design/okl2srgb_pkg.sv
package okl2srgb_pkg;

    localparam int FRAC_BITS             = 16;
    localparam int GAMMA_TABLE_ADDR_BITS = 10;

    localparam int FIELD_W = 20;
    localparam int ALPHA_W = 17;

    // OKLab -> LMS'
    localparam int LVW   = FRAC_BITS + 2;
    localparam int M1C_W = 22;
    localparam int P1W   = FIELD_W + M1C_W;
    localparam int S1W   = ((FRAC_BITS + 21 > P1W) ? FRAC_BITS + 21 : P1W) + 2;
    localparam int LW    = (FRAC_BITS <= 18) ? 21 : FRAC_BITS + 3;
    // cube
    localparam int TW    = 2 * LW - FRAC_BITS;
    localparam int CW    = 3 * LW - 2 * FRAC_BITS - 1;
    // LMS -> linear RGB
    localparam int M2C_W = 24;
    localparam int P2W   = CW + M2C_W;
    localparam int S2W   = P2W + 2;
    localparam int VW    = FRAC_BITS + 10;
    // transfer curve
    localparam int XW    = FRAC_BITS + 9;
    localparam int NW    = $clog2(XW);
    localparam int TQ    = 26;
    localparam int GW    = 27;
    localparam int SHW   = 6;
    localparam int RW    = 4;
    localparam int LIN_C_W = 25;
    localparam int LPW   = VW + LIN_C_W;
    localparam int PW    = 28;
    localparam int PM_W  = 49;
    localparam int EW    = PM_W + 2 - 19;
    localparam int SATW  = 40;

    localparam longint ONE_L  = longint'(64'd1 << FRAC_BITS);
    localparam longint VMAX_L = longint'(64'd256 << FRAC_BITS);
    localparam longint THR_L  =
        longint'((64'd13446684 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam longint OFF_L  =
        longint'((64'd236223201 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam longint LIM_L  = longint'(64'd8 << FRAC_BITS);
    localparam longint SAT_HI = (LIM_L < 524288) ? LIM_L : 524287;
    localparam longint SAT_LO = (LIM_L < 524288) ? -LIM_L : -524288;

    localparam logic signed [M1C_W-1:0] M1_A [3] = '{22'sd415590, -22'sd110689, -22'sd93831};
    localparam logic signed [M1C_W-1:0] M1_B [3] = '{22'sd226287, -22'sd66956, -22'sd1354221};

    localparam logic signed [M2C_W-1:0] M2 [3][3] = '{
        '{ 24'sd4274773, -24'sd3468387,  24'sd242190},
        '{-24'sd1330054,  24'sd2736529, -24'sd357899},
        '{-24'sd4400,    -24'sd737588,   24'sd1790564}
    };

    localparam logic signed [LIN_C_W-1:0] LIN_C = 25'sd13547602;
    localparam logic [20:0]               PM_C  = 21'd1106248;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic [ALPHA_W-1:0]        alpha_t;
    typedef logic signed [CW-1:0]      lms_t;
    typedef logic signed [VW-1:0]      lin_t;

    function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
        return (a * b) >> TQ;
    endfunction

    function automatic longint unsigned pow12(input longint unsigned y);
        longint unsigned y2, y4, y8;
        y2 = qmul(y, y);
        y4 = qmul(y2, y2);
        y8 = qmul(y4, y4);
        return qmul(y8, y4);
    endfunction

    // largest Q26 y with y^12 <= t
    function automatic longint unsigned root12(input longint unsigned t);
        longint unsigned y, c;
        y = 64'd0;
        for (int b = TQ; b >= 0; b--) begin
            c = y | (64'd1 << b);
            if (pow12(c) <= t) y = c;
        end
        return y;
    endfunction

    // m^(5/12) at m = 1 + k/2^abits
    function automatic longint unsigned gamma_entry(input int abits, input int k);
        longint unsigned m, m2, m4;
        m  = (64'd1 << TQ) + (longint'(k) << (TQ - abits));
        m2 = qmul(m, m);
        m4 = qmul(m2, m2);
        return root12(qmul(m4, m));
    endfunction

    function automatic logic [12*GW-1:0] build_rtab();
        logic [12*GW-1:0] t;
        t = '0;
        for (int r = 0; r < 12; r++) t[r*GW +: GW] = GW'(root12(64'd1 << (TQ + r)));
        return t;
    endfunction

    localparam logic [12*GW-1:0] RTAB = build_rtab();

    // exponent split: 5e = 12q + r, returns {final shift, r}
    function automatic logic [SHW+RW-1:0] exp_split(input logic [NW-1:0] n);
        int s;
        int q;
        s = 5 * int'(n) - 5 * FRAC_BITS + 120;
        q = s / 12 - 10;
        return {SHW'(46 - FRAC_BITS - q), RW'(s % 12)};
    endfunction

    // split for every leading-one position, looked up by position
    function automatic logic [(1<<NW)*(SHW+RW)-1:0] build_split();
        logic [(1<<NW)*(SHW+RW)-1:0] t;
        t = '0;
        for (int n = 0; n < (1 << NW); n++) t[n*(SHW+RW) +: SHW+RW] = exp_split(NW'(n));
        return t;
    endfunction

    localparam logic [(1<<NW)*(SHW+RW)-1:0] SPLIT_TAB = build_split();

    function automatic field_t sat_out(input logic signed [SATW-1:0] y);
        if (y > SAT_HI) return FIELD_W'(SAT_HI);
        if (y < SAT_LO) return FIELD_W'(SAT_LO);
        return y[FIELD_W-1:0];
    endfunction

endpackage

>>> design/oklab_to_srgb_converter.sv
// OKLab to gamma-encoded sRGB, one colour item per clock unless the output stalls.
// The pipeline has 14 register stages. Throughput: one item per cycle unless the output
// stalls with every stage full; each stage holds its item while the next is full, so
// bubbles are squeezed out and s_ready only drops when all stages are occupied.
// The transfer-curve table is a ROM of 2^GAMMA_TABLE_ADDR_BITS+1 entries per channel.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
module oklab_to_srgb_converter #(
    parameter int GAMMA_TABLE_ADDR_BITS = okl2srgb_pkg::GAMMA_TABLE_ADDR_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  okl2srgb_pkg::field_t s_lightness,
    input  okl2srgb_pkg::field_t s_axis_a,
    input  okl2srgb_pkg::field_t s_axis_b,
    input  okl2srgb_pkg::alpha_t s_alpha_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output okl2srgb_pkg::field_t m_red,
    output okl2srgb_pkg::field_t m_green,
    output okl2srgb_pkg::field_t m_blue,
    output okl2srgb_pkg::alpha_t m_alpha_out
);
    localparam int NST = 14;

    logic [NST-1:0]        v_reg;
    logic [NST-1:0]        en;
    okl2srgb_pkg::alpha_t  alpha_reg [NST];
    okl2srgb_pkg::lms_t    lms [3];
    okl2srgb_pkg::lin_t    lin [3];
    okl2srgb_pkg::field_t  rgb [3];

    always_comb begin
        en[NST-1] = !v_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_valid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) alpha_reg[0] <= s_alpha_in;
        for (int i = 1; i < NST; i++) begin
            if (en[i]) alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    okl2srgb_lms u_lms (
        .aclk      (aclk),
        .en        (en[3:0]),
        .lightness (s_lightness),
        .axis_a    (s_axis_a),
        .axis_b    (s_axis_b),
        .lms_o     (lms)
    );

    okl2srgb_rgb u_rgb (
        .aclk  (aclk),
        .en    (en[5:4]),
        .lms_i (lms),
        .lin_o (lin)
    );

    for (genvar c = 0; c < 3; c++) begin : g_enc
        okl2srgb_enc #(
            .ADDR_BITS (GAMMA_TABLE_ADDR_BITS)
        ) u_enc (
            .aclk (aclk),
            .en   (en[13:6]),
            .v_i  (lin[c]),
            .y_o  (rgb[c])
        );
    end

    assign s_ready     = en[0];
    assign m_valid     = v_reg[NST-1];
    assign m_red       = rgb[0];
    assign m_green     = rgb[1];
    assign m_blue      = rgb[2];
    assign m_alpha_out = alpha_reg[NST-1];

endmodule

>>> design/okl2srgb_lms.sv
module okl2srgb_lms (
    input  logic                  aclk,
    input  logic [3:0]            en,
    input  okl2srgb_pkg::field_t  lightness,
    input  okl2srgb_pkg::field_t  axis_a,
    input  okl2srgb_pkg::field_t  axis_b,
    output okl2srgb_pkg::lms_t    lms_o [3]
);
    localparam int F   = okl2srgb_pkg::FRAC_BITS;
    localparam int LVW = okl2srgb_pkg::LVW;
    localparam int P1W = okl2srgb_pkg::P1W;
    localparam int S1W = okl2srgb_pkg::S1W;
    localparam int LW  = okl2srgb_pkg::LW;
    localparam int TW  = okl2srgb_pkg::TW;
    localparam int CW  = okl2srgb_pkg::CW;

    logic signed [LVW-1:0]   lv_next, lv_reg;
    logic signed [P1W-1:0]   pa_next [3], pb_next [3], pa_reg [3], pb_reg [3];
    logic signed [S1W-1:0]   lv_sh, sum1 [3];
    logic signed [LW-1:0]    lp_next [3], lp_reg [3], lp3_reg [3];
    logic signed [2*LW-1:0]  sq_next [3], sq_reg [3], rsq [3];
    logic signed [TW-1:0]    t [3];
    logic signed [TW+LW-1:0] tl_next [3], tl_reg [3], rtl [3];

    always_comb begin
        if (lightness < 0) begin
            lv_next = '0;
        end else if (lightness > okl2srgb_pkg::ONE_L) begin
            lv_next = LVW'(okl2srgb_pkg::ONE_L);
        end else begin
            lv_next = LVW'(lightness);
        end
        for (int i = 0; i < 3; i++) begin
            pa_next[i] = axis_a * okl2srgb_pkg::M1_A[i];
            pb_next[i] = axis_b * okl2srgb_pkg::M1_B[i];
        end
    end

    always_comb begin
        lv_sh = S1W'(lv_reg) <<< 20;
        for (int i = 0; i < 3; i++) begin
            sum1[i]    = lv_sh + pa_reg[i] + pb_reg[i] + S1W'(1 <<< 19);
            lp_next[i] = sum1[i][LW+19:20];
            sq_next[i] = lp_reg[i] * lp_reg[i];
            rsq[i]     = sq_reg[i] + (2*LW)'(1 <<< (F - 1));
            t[i]       = rsq[i][2*LW-1:F];
            tl_next[i] = t[i] * lp3_reg[i];
            rtl[i]     = tl_reg[i] + (TW+LW)'(1 <<< (F - 1));
            lms_o[i]   = rtl[i][F+CW-1:F];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lv_reg <= lv_next;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (en[1]) lp_reg <= lp_next;
        if (en[2]) begin
            sq_reg  <= sq_next;
            lp3_reg <= lp_reg;
        end
        if (en[3]) tl_reg <= tl_next;
    end

endmodule

>>> design/okl2srgb_rgb.sv
module okl2srgb_rgb (
    input  logic                aclk,
    input  logic [1:0]          en,
    input  okl2srgb_pkg::lms_t  lms_i [3],
    output okl2srgb_pkg::lin_t  lin_o [3]
);
    localparam int P2W = okl2srgb_pkg::P2W;
    localparam int S2W = okl2srgb_pkg::S2W;
    localparam int VW  = okl2srgb_pkg::VW;

    logic signed [P2W-1:0]    p_next [3][3], p_reg [3][3];
    logic signed [S2W-1:0]    sum2 [3];
    logic signed [S2W-21:0]   lr [3];
    okl2srgb_pkg::lin_t       v_next [3], v_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) p_next[i][j] = lms_i[j] * okl2srgb_pkg::M2[i][j];
            sum2[i] = p_reg[i][0] + p_reg[i][1] + p_reg[i][2] + S2W'(1 <<< 19);
            lr[i]   = sum2[i][S2W-1:20];
            // range needed by either branch of the curve
            if (lr[i] < -okl2srgb_pkg::ONE_L) begin
                v_next[i] = VW'(-okl2srgb_pkg::ONE_L);
            end else if (lr[i] > okl2srgb_pkg::VMAX_L) begin
                v_next[i] = VW'(okl2srgb_pkg::VMAX_L);
            end else begin
                v_next[i] = VW'(lr[i]);
            end
        end
    end

    assign lin_o = v_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) p_reg <= p_next;
        if (en[1]) v_reg <= v_next;
    end

endmodule

>>> design/okl2srgb_enc.sv
module okl2srgb_enc #(
    parameter int ADDR_BITS = okl2srgb_pkg::GAMMA_TABLE_ADDR_BITS
) (
    input  logic                 aclk,
    input  logic [7:0]           en,
    input  okl2srgb_pkg::lin_t   v_i,
    output okl2srgb_pkg::field_t y_o
);
    localparam int VW    = okl2srgb_pkg::VW;
    localparam int XW    = okl2srgb_pkg::XW;
    localparam int NW    = okl2srgb_pkg::NW;
    localparam int GW    = okl2srgb_pkg::GW;
    localparam int SHW   = okl2srgb_pkg::SHW;
    localparam int RW    = okl2srgb_pkg::RW;
    localparam int LPW   = okl2srgb_pkg::LPW;
    localparam int PW    = okl2srgb_pkg::PW;
    localparam int PM_W  = okl2srgb_pkg::PM_W;
    localparam int PMX_W = PM_W + 1;
    localparam int EW    = okl2srgb_pkg::EW;
    localparam int SATW  = okl2srgb_pkg::SATW;
    localparam int GSIZE = (1 << ADDR_BITS) + 1;
    localparam int WSW   = XW - 1 - ADDR_BITS;
    localparam int DWW   = GW + WSW;

    function automatic logic [GSIZE*GW-1:0] build_gtab();
        logic [GSIZE*GW-1:0] tab;
        tab = '0;
        for (int k = 0; k < GSIZE; k++) begin
            tab[k*GW +: GW] = GW'(okl2srgb_pkg::gamma_entry(ADDR_BITS, k));
        end
        return tab;
    endfunction

    localparam logic [GSIZE*GW-1:0] GTAB = build_gtab();
    localparam logic signed [EW-1:0] OFF_E = EW'(okl2srgb_pkg::OFF_L);

    logic                    lin_reg  [7];
    logic signed [LPW-1:0]   linp_reg [7];
    logic [SHW-1:0]          sh_reg   [1:6];
    logic [RW-1:0]           r_reg    [1:4];

    logic                    lin0_next;
    logic signed [VW-1:0]    vlin;
    logic signed [LPW-1:0]   linp0_next;
    logic [XW-1:0]           x_next, x_reg, xn;
    logic [NW-1:0]           n_next, n_reg;
    logic [SHW+RW-1:0]       split;
    logic [ADDR_BITS-1:0]    k_reg;
    logic [WSW-1:0]          w1_reg, w2_reg;
    logic [GW-1:0]           g0_2_reg, g1_2_reg, g0_3_reg, g_next, g_reg;
    logic [DWW-1:0]          dw_reg;
    logic [2*GW-1:0]         gp_reg;
    logic [PM_W-1:0]         pm_reg;
    logic [PMX_W-1:0]        half, rsum, rsh;
    logic signed [EW-1:0]    powv;
    logic signed [LPW-1:0]   linr;
    logic signed [LPW-21:0]  lin_y;
    okl2srgb_pkg::field_t    y_next, y_reg;

    // curve select, linear segment product, leading one
    always_comb begin
        lin0_next  = v_i <= okl2srgb_pkg::THR_L;
        vlin       = (v_i < -okl2srgb_pkg::ONE_L) ? VW'(-okl2srgb_pkg::ONE_L) : v_i;
        linp0_next = vlin * okl2srgb_pkg::LIN_C;
        x_next     = v_i[XW-1:0];
        n_next     = '0;
        for (int i = 0; i < XW; i++) begin
            if (x_next[i]) n_next = NW'(i);
        end
    end

    assign xn     = x_reg << (NW'(XW - 1) - n_reg);
    assign split  = okl2srgb_pkg::SPLIT_TAB[n_reg*(SHW+RW) +: SHW+RW];
    assign g_next = g0_3_reg + dw_reg[DWW-1:WSW];

    always_comb begin
        half  = PMX_W'(1) << (sh_reg[6] - SHW'(1));
        rsum  = {1'b0, pm_reg} + half;
        rsh   = rsum >> sh_reg[6];
        powv  = $signed({1'b0, rsh[EW-2:0]}) - OFF_E;
        linr  = linp_reg[6] + LPW'(1 <<< 19);
        lin_y = linr[LPW-1:20];
        if (lin_reg[6]) begin
            y_next = okl2srgb_pkg::sat_out(SATW'(lin_y));
        end else begin
            y_next = okl2srgb_pkg::sat_out(SATW'(powv));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lin_reg[0]  <= lin0_next;
            linp_reg[0] <= linp0_next;
            x_reg       <= x_next;
            n_reg       <= n_next;
        end
        for (int i = 1; i < 7; i++) begin
            if (en[i]) begin
                lin_reg[i]  <= lin_reg[i-1];
                linp_reg[i] <= linp_reg[i-1];
            end
        end
        if (en[1]) begin
            k_reg     <= xn[XW-2 -: ADDR_BITS];
            w1_reg    <= xn[WSW-1:0];
            sh_reg[1] <= split[SHW+RW-1:RW];
            r_reg[1]  <= split[RW-1:0];
        end
        for (int i = 2; i < 7; i++) begin
            if (en[i]) sh_reg[i] <= sh_reg[i-1];
        end
        for (int i = 2; i < 5; i++) begin
            if (en[i]) r_reg[i] <= r_reg[i-1];
        end
        // table read, neighbouring entries for interpolation
        if (en[2]) begin
            g0_2_reg <= GTAB[k_reg*GW +: GW];
            g1_2_reg <= GTAB[(k_reg + 1)*GW +: GW];
            w2_reg   <= w1_reg;
        end
        if (en[3]) begin
            dw_reg   <= (g1_2_reg - g0_2_reg) * w2_reg;
            g0_3_reg <= g0_2_reg;
        end
        if (en[4]) g_reg  <= g_next;
        if (en[5]) gp_reg <= g_reg * okl2srgb_pkg::RTAB[r_reg[4]*GW +: GW];
        if (en[6]) pm_reg <= gp_reg[okl2srgb_pkg::TQ +: PW] * okl2srgb_pkg::PM_C;
        if (en[7]) y_reg  <= y_next;
    end

    assign y_o = y_reg;

endmodule

>>> design/okl2srgb_chk.sv
module okl2srgb_chk (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input okl2srgb_pkg::field_t s_lightness,
    input okl2srgb_pkg::field_t s_axis_a,
    input okl2srgb_pkg::field_t s_axis_b,
    input okl2srgb_pkg::alpha_t s_alpha_in,
    input logic                 m_valid,
    input logic                 m_ready,
    input okl2srgb_pkg::field_t m_red,
    input okl2srgb_pkg::field_t m_green,
    input okl2srgb_pkg::field_t m_blue,
    input okl2srgb_pkg::alpha_t m_alpha_out
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_lightness) && $stable(s_axis_a)
                                && $stable(s_axis_b) && $stable(s_alpha_in))
        else $error("waiting input item changed or withdrawn");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue) && $stable(m_alpha_out))
        else $error("stalled item changed or dropped");

    // an empty output stage means the pipe has room
    a_room_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output stage empty");

    a_room_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is being taken");

endmodule

bind oklab_to_srgb_converter okl2srgb_chk u_okl2srgb_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_lightness (s_lightness),
    .s_axis_a    (s_axis_a),
    .s_axis_b    (s_axis_b),
    .s_alpha_in  (s_alpha_in),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_red       (m_red),
    .m_green     (m_green),
    .m_blue      (m_blue),
    .m_alpha_out (m_alpha_out)
);

>>> tb/tb_oklab_to_srgb_converter.sv
module tb_oklab_to_srgb_converter;
    typedef okl2srgb_pkg::field_t field_t;
    typedef okl2srgb_pkg::alpha_t alpha_t;

    localparam int FB   = okl2srgb_pkg::FRAC_BITS;
    localparam int AB   = okl2srgb_pkg::GAMMA_TABLE_ADDR_BITS;
    localparam int MQ   = 26;
    localparam int NORM = 40;

    typedef struct {
        field_t r;
        field_t g;
        field_t b;
        alpha_t a;
    } pixel_t;

    class colour_scoreboard;
        longint unsigned mant_pow [(1 << AB) + 1];
        longint unsigned oct_pow [12];
        pixel_t pending_px [$];
        int errors;

        function new();
            longint unsigned m, m2, m4;
            errors = 0;
            for (int k = 0; k <= (1 << AB); k++) begin
                m  = (64'd1 << MQ) + (longint'(k) << (MQ - AB));
                m2 = fmul(m, m);
                m4 = fmul(m2, m2);
                mant_pow[k] = twelfth_root(fmul(m4, m));
            end
            for (int r = 0; r < 12; r++) oct_pow[r] = twelfth_root(64'd1 << (MQ + r));
        endfunction

        function longint unsigned fmul(longint unsigned a, longint unsigned b);
            return (a * b) >> MQ;
        endfunction

        function longint unsigned twelfth_root(longint unsigned t);
            longint unsigned y, c, c2, c4, c8;
            y = 0;
            for (int bit_i = MQ; bit_i >= 0; bit_i--) begin
                c  = y | (64'd1 << bit_i);
                c2 = fmul(c, c);
                c4 = fmul(c2, c2);
                c8 = fmul(c4, c4);
                if (fmul(c8, c4) <= t) y = c;
            end
            return y;
        endfunction

        function longint round_shift(longint v, int k);
            return (v + (longint'(1) << (k - 1))) >>> k;
        endfunction

        function longint clip_out(longint y);
            longint lim, hi, lo;
            lim = longint'(8) << FB;
            hi  = lim < 524288 ? lim : 524287;
            lo  = lim < 524288 ? -lim : -524288;
            if (y > hi) return hi;
            if (y < lo) return lo;
            return y;
        endfunction

        // linear light -> gamma encoded
        function longint gamma_encode(longint v);
            longint one, thr, off;
            longint unsigned x, fr, w, g;
            int n, k, e, s, q, r;
            one = longint'(1) << FB;
            thr = (longint'(13446684) + (longint'(1) << (31 - FB))) >> (32 - FB);
            off = (longint'(236223201) + (longint'(1) << (31 - FB))) >> (32 - FB);
            if (v <= thr) begin
                if (v < -one) v = -one;
                return clip_out(round_shift(v * 13547602, 20));
            end
            if (v > 256 * one) v = 256 * one;
            x = v;
            n = 0;
            while ((x >> (n + 1)) != 0) n++;
            x  = x << (NORM - n);
            fr = x - (64'd1 << NORM);
            k  = int'(fr >> (NORM - AB));
            w  = fr & ((64'd1 << (NORM - AB)) - 1);
            g  = mant_pow[k] + (((mant_pow[k+1] - mant_pow[k]) * w) >> (NORM - AB));
            e  = n - FB;
            s  = 5 * e + 120;
            q  = s / 12 - 10;
            r  = s % 12;
            return clip_out(round_shift(longint'(fmul(g, oct_pow[r])) * 1106248,
                                        46 - FB - q) - off);
        endfunction

        function longint cube(longint v);
            return round_shift(round_shift(v * v, FB) * v, FB);
        endfunction

        function void note_colour(field_t l, field_t a, field_t b, alpha_t al);
            longint lv, av, bv, lc, mc, sc, lr, lg, lb;
            pixel_t px;
            lv = l;
            av = a;
            bv = b;
            if (lv < 0) lv = 0;
            if (lv > (longint'(1) << FB)) lv = longint'(1) << FB;
            lc = cube(round_shift(lv * 1048576 + 415590 * av + 226287 * bv, 20));
            mc = cube(round_shift(lv * 1048576 - 110689 * av - 66956 * bv, 20));
            sc = cube(round_shift(lv * 1048576 - 93831 * av - 1354221 * bv, 20));
            lr = round_shift(4274773 * lc - 3468387 * mc + 242190 * sc, 20);
            lg = round_shift(-1330054 * lc + 2736529 * mc - 357899 * sc, 20);
            lb = round_shift(-4400 * lc - 737588 * mc + 1790564 * sc, 20);
            px.r = field_t'(gamma_encode(lr));
            px.g = field_t'(gamma_encode(lg));
            px.b = field_t'(gamma_encode(lb));
            px.a = al;
            pending_px.push_back(px);
        endfunction

        function void check_pixel(field_t r, field_t g, field_t b, alpha_t a);
            pixel_t px;
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected item r=%0d g=%0d b=%0d a=%0d", $time, r, g, b, a);
                errors++;
                return;
            end
            px = pending_px.pop_front();
            if (r !== px.r) begin
                $display("%0t: red expected %0d got %0d", $time, px.r, r);
                errors++;
            end
            if (g !== px.g) begin
                $display("%0t: green expected %0d got %0d", $time, px.g, g);
                errors++;
            end
            if (b !== px.b) begin
                $display("%0t: blue expected %0d got %0d", $time, px.b, b);
                errors++;
            end
            if (a !== px.a) begin
                $display("%0t: alpha expected %0d got %0d", $time, px.a, a);
                errors++;
            end
        endfunction
    endclass

    logic   aclk = 0;
    logic   aresetn = 0;
    logic   s_valid = 0;
    logic   s_ready;
    field_t s_lightness = '0;
    field_t s_axis_a = '0;
    field_t s_axis_b = '0;
    alpha_t s_alpha_in = '0;
    logic   m_valid;
    logic   m_ready = 0;
    field_t m_red, m_green, m_blue;
    alpha_t m_alpha_out;

    colour_scoreboard sb = new();
    int tx_idle = 24;
    int rx_idle = 48;
    bit hold_req = 0;
    int hold_left = 0;

    oklab_to_srgb_converter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_lightness(s_lightness), .s_axis_a(s_axis_a), .s_axis_b(s_axis_b),
        .s_alpha_in(s_alpha_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_alpha_out(m_alpha_out)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_colour(s_lightness, s_axis_a, s_axis_b, s_alpha_in);
            if (m_valid && m_ready) sb.check_pixel(m_red, m_green, m_blue, m_alpha_out);
        end
    end

    // receiver: random back-pressure plus one long hold-off when requested
    always @(posedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 90;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
            if (hold_left == 0) hold_req = 0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_colour(field_t l, field_t a, field_t b, alpha_t al);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_lightness <= l;
        s_axis_a    <= a;
        s_axis_b    <= b;
        s_alpha_in  <= al;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random();
        field_t l, a, b;
        alpha_t al;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            // plausible colours inside the gamut neighbourhood
            l = field_t'($urandom_range(65536));
            a = field_t'(int'($urandom_range(52428)) - 26214);
            b = field_t'(int'($urandom_range(52428)) - 26214);
        end else if (pick < 80) begin
            l = field_t'($urandom);
            a = field_t'(int'($urandom_range(131072)) - 65536);
            b = field_t'(int'($urandom_range(131072)) - 65536);
        end else begin
            l = field_t'($urandom);
            a = field_t'($urandom);
            b = field_t'($urandom);
        end
        if ($urandom_range(9) == 0) al = alpha_t'($urandom);
        else al = alpha_t'($urandom_range(65536));
        send_colour(l, a, b, al);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_px.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_colour('0, '0, '0, '0);
        send_colour(20'sd65536, '0, '0, 17'd65536);
        send_colour(-20'sd1, '0, '0, 17'h1FFFF);
        send_colour(20'sd524287, '0, '0, 17'd1);
        send_colour(-20'sd524288, '0, '0, 17'd0);
        send_colour(20'sd65537, '0, '0, 17'd100);
        send_colour(20'sd32768, 20'sd524287, 20'sd524287, 17'd65535);
        send_colour(20'sd32768, -20'sd524288, -20'sd524288, 17'd0);
        send_colour(20'sd32768, 20'sd524287, -20'sd524288, 17'd0);
        send_colour(20'sd32768, -20'sd524288, 20'sd524287, 17'd0);
        send_colour('0, 20'sd524287, '0, 17'd0);
        send_colour('0, '0, -20'sd524288, 17'd0);
        send_colour(20'sd65536, 20'sd524287, 20'sd524287, 17'h10000);
        // near black: linear segment and the threshold
        send_colour(20'sd9500, '0, '0, 17'd1);
        send_colour(20'sd9600, '0, '0, 17'd2);
        send_colour(20'sd9700, '0, '0, 17'd3);
        send_colour(20'sd1, '0, '0, 17'd4);
        // negative linear channels from saturated hues
        send_colour(20'sd40000, 20'sd20000, '0, 17'd5);
        send_colour(20'sd40000, -20'sd20000, 20'sd20000, 17'd6);
        send_colour(20'sd50000, '0, -20'sd25000, 17'd7);
        send_colour(20'sd65536, -20'sd30000, '0, 17'd8);

        tx_idle = 24;
        rx_idle = 48;
        repeat (560) send_random();

        tx_idle = 48;
        rx_idle = 24;
        repeat (560) send_random();

        // sender pauses until the pipeline is empty
        wait_drained();

        tx_idle = 0;
        rx_idle = 0;
        hold_req = 1;
        repeat (560) send_random();

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_px.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end
endmodule
